@@ src/lbs_pkg.sv @@
package lbs_pkg;

   // Register widths
   localparam int unsigned INTERVAL_W = 16;
   localparam int unsigned COUNT_W    = 8;
   localparam int unsigned STEP_W     = COUNT_W + 1;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned CSR_ADDR_W = 2;

   // Reset values of the configuration registers
   localparam logic [INTERVAL_W-1:0] BLINK_INTERVAL_RST = 16'd1000;

   // Register indexes on the configuration port
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_BLINK_INTERVAL = 2'd0,
      CSR_SEQ_COUNT      = 2'd1,
      CSR_SEQ_ON_LENGTH  = 2'd2,
      CSR_SEQ_OFF_WAIT   = 2'd3
   } csr_index_type;

   // Request commands
   typedef enum logic [1:0] {
      CMD_TICK     = 2'd0,
      CMD_SET_MODE = 2'd1,
      CMD_RESTART  = 2'd2
   } command_type;

   // LED modes
   typedef enum logic [1:0] {
      MODE_OFF    = 2'd0,
      MODE_STEADY = 2'd1,
      MODE_BLINK  = 2'd2,
      MODE_SEQ    = 2'd3
   } mode_type;

   typedef struct packed {
      logic [INTERVAL_W-1:0] blink_interval;
      logic [COUNT_W-1:0]    seq_count;
      logic [INTERVAL_W-1:0] seq_on_length;
      logic [INTERVAL_W-1:0] seq_off_wait;
   } cfg_type;

   typedef struct packed {
      logic [1:0] command;
      logic [1:0] new_mode;
   } req_type;

   typedef struct packed {
      logic       led_lit;
      logic       sequence_done;
      logic [1:0] current_mode;
   } rsp_type;

endpackage

@@ src/lbs_csr.sv @@
module lbs_csr
   import lbs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write to one register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_addr)
            CSR_BLINK_INTERVAL: cfg_in.blink_interval = csr_wr_data[INTERVAL_W-1:0];
            CSR_SEQ_COUNT:      cfg_in.seq_count      = csr_wr_data[COUNT_W-1:0];
            CSR_SEQ_ON_LENGTH:  cfg_in.seq_on_length  = csr_wr_data[INTERVAL_W-1:0];
            CSR_SEQ_OFF_WAIT:   cfg_in.seq_off_wait   = csr_wr_data[INTERVAL_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blink_interval <= BLINK_INTERVAL_RST;
         cfg_ff.seq_count      <= '0;
         cfg_ff.seq_on_length  <= '0;
         cfg_ff.seq_off_wait   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ src/lbs_req_stage.sv @@
module lbs_req_stage
   import lbs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  req_type req_in,
   input  logic    take,
   output logic    req_valid,
   output req_type req_out
);

   logic    valid_ff;
   logic    valid_in;
   req_type req_ff;

   // Accept a new request whenever the held one is empty or leaving
   assign req_tready = !valid_ff || take;
   assign valid_in   = req_tvalid || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_tready) begin
         valid_ff <= valid_in;
      end
   end

   // Hold the request payload
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_ff <= req_in;
      end
   end

   assign req_valid = valid_ff;
   assign req_out   = req_ff;

endmodule

@@ src/lbs_engine.sv @@
module lbs_engine
   import lbs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_valid,
   input  req_type req,
   output logic    take,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output rsp_type rsp
);

   mode_type              mode_ff, mode_in;
   logic                  lit_ff, lit_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [INTERVAL_W-1:0] wait_ff, wait_in;
   logic                  done_ff, done_in;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   logic [INTERVAL_W-1:0] wait_dec;
   logic [STEP_W-1:0]     step_inc;
   logic [STEP_W-1:0]     step_last;
   mode_type              req_mode;

   // Move a request into the result register when that register frees up
   assign take = req_valid && (!rsp_valid_ff || rsp_tready);

   assign wait_dec  = (wait_ff != '0) ? wait_ff - 1'b1 : '0;
   assign step_inc  = step_ff + 1'b1;
   assign step_last = {cfg.seq_count, 1'b0};
   assign req_mode  = mode_type'(req.new_mode);

   // Next LED state for one request
   always_comb begin
      mode_in = mode_ff;
      lit_in  = lit_ff;
      step_in = step_ff;
      wait_in = wait_ff;
      done_in = done_ff;
      case (command_type'(req.command))
         CMD_TICK: begin
            wait_in = wait_dec;
            if (wait_dec == '0) begin
               if (mode_ff == MODE_BLINK) begin
                  wait_in = cfg.blink_interval;
                  lit_in  = !lit_ff;
               end else if (mode_ff == MODE_SEQ) begin
                  if (step_ff == '0) begin
                     step_in = {{(STEP_W-1){1'b0}}, 1'b1};
                     lit_in  = 1'b1;
                     wait_in = cfg.seq_on_length;
                  end else if (step_ff >= step_last) begin
                     // Sequence finished: fall back to off
                     mode_in = MODE_OFF;
                     step_in = '0;
                     done_in = 1'b1;
                     lit_in  = 1'b0;
                  end else begin
                     step_in = step_inc;
                     lit_in  = step_inc[0];
                     wait_in = step_inc[0] ? cfg.seq_on_length : cfg.seq_off_wait;
                  end
               end
            end
         end
         CMD_SET_MODE: begin
            mode_in = req_mode;
            if (req_mode != mode_ff) begin
               if (req_mode == MODE_OFF) begin
                  lit_in = 1'b0;
               end else if (req_mode == MODE_STEADY) begin
                  lit_in = 1'b1;
               end else if (req_mode == MODE_SEQ) begin
                  step_in = '0;
                  done_in = 1'b0;
                  lit_in  = 1'b0;
                  wait_in = '0;
               end
            end
         end
         CMD_RESTART: begin
            step_in = '0;
            done_in = 1'b0;
            lit_in  = 1'b0;
            wait_in = '0;
         end
         default: begin
            mode_in = mode_ff;
         end
      endcase
   end

   // Commit state on every request taken
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_STEADY;
         lit_ff  <= 1'b1;
         step_ff <= '0;
         wait_ff <= '0;
         done_ff <= 1'b0;
      end else if (take) begin
         mode_ff <= mode_in;
         lit_ff  <= lit_in;
         step_ff <= step_in;
         wait_ff <= wait_in;
         done_ff <= done_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_tready) begin
         rsp_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff.led_lit       <= lit_in;
         rsp_ff.sequence_done <= done_in;
         rsp_ff.current_mode  <= mode_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp        = rsp_ff;

endmodule

@@ src/led_blink_sequencer_top.sv @@
// LED blink sequencer.
// Request channel (req_*): one item per request, a 1 ms tick, a mode change
// (off, steady, blink, pulse sequence) or a sequence restart.
// Response channel (rsp_*): exactly one result per request, in order, with
// the LED level, the sequence-done flag and the mode after that request.
// Configuration (csr_*): a write sets blink_interval, seq_count,
// seq_on_length or seq_off_wait; write only while no request is in flight.
// Path: a request accepted at a clock edge goes into the request register, feeds
// the next-state logic, and its result is captured in the result register, which
// drives rsp_tdata and holds its output.
// Throughput: one request per cycle while rsp_tready is high; the LED state
// registers are updated in the same cycle the result is registered.
// Stall: with rsp_tready low the result holds, the request register still
// takes one more request, and req_tready then drops until the result leaves.
// Reset: mode steady, LED lit, no sequence in progress, done flag clear,
// blink_interval 1000 and other registers zero; both channels empty.
module led_blink_sequencer_top
   import lbs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [1:0] command, [3:2] new_mode, [7:4] zero
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // [0] led_lit, [1] sequence_done,
                                              // [3:2] current_mode, [7:4] zero
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   cfg_type cfg;
   req_type req_in;
   req_type req_held;
   rsp_type rsp;
   logic    req_valid;
   logic    take;

   assign req_in.command  = req_tdata[1:0];
   assign req_in.new_mode = req_tdata[3:2];

   lbs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   lbs_req_stage u_req_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_in     (req_in),
      .take       (take),
      .req_valid  (req_valid),
      .req_out    (req_held)
   );

   lbs_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_valid  (req_valid),
      .req        (req_held),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp        (rsp)
   );

   // Pack the result
   assign rsp_tdata = {4'b0000, rsp.current_mode, rsp.sequence_done, rsp.led_lit};

endmodule
